// ===== design/crrb_pkg.sv =====
// Shared types and constants of the contiguous record ring buffer.
`timescale 1ns / 1ps

package crrb_pkg;

  // Ring geometry
  localparam int DEPTH     = 1024;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int PTR_W     = ADDR_W + 1;     // pointers reach DEPTH itself
  localparam int SUM_W     = PTR_W + 1;      // pointer plus record length
  localparam int WORD_BITS = 32;
  localparam int LEN_W     = 10;
  localparam int OP_W      = 2;
  localparam int STS_W     = 3;

  localparam logic [PTR_W-1:0] HDR_WORDS       = PTR_W'(1);
  localparam logic [PTR_W-1:0] RING_SIZE_MIN   = PTR_W'(2);
  localparam logic [PTR_W-1:0] RING_SIZE_RESET = PTR_W'(DEPTH);

  // Operation codes
  localparam logic [OP_W-1:0] OP_BEGIN = 2'd0;
  localparam logic [OP_W-1:0] OP_DATA  = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;
  localparam logic [OP_W-1:0] OP_DONE  = 2'd3;

  // Status codes
  localparam logic [STS_W-1:0] STS_OK        = 3'd0;
  localparam logic [STS_W-1:0] STS_NO_SPACE  = 3'd1;
  localparam logic [STS_W-1:0] STS_TOO_LARGE = 3'd2;
  localparam logic [STS_W-1:0] STS_ZERO_LEN  = 3'd3;
  localparam logic [STS_W-1:0] STS_EMPTY     = 3'd4;
  localparam logic [STS_W-1:0] STS_SEQ_ERR   = 3'd5;
  localparam logic [STS_W-1:0] STS_OFFSET    = 3'd6;

  typedef struct packed {
    logic [OP_W-1:0]      op;
    logic [LEN_W-1:0]     record_len;
    logic [WORD_BITS-1:0] data_in;
    logic [LEN_W-1:0]     read_offset;
  } crrb_req_t;

  typedef struct packed {
    logic [STS_W-1:0]     status;
    logic [WORD_BITS-1:0] data_out;
    logic [LEN_W-1:0]     oldest_len;
    logic                 committed;
  } crrb_rsp_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;    // latch a new item
    logic cfg_wr;    // write ring size, empty the ring
    logic exec;      // carry out the operation
    logic hdr;       // header of the oldest record is in rd_data
    logic view;      // look up the oldest readable record
    logic view_cap;  // its header is in rd_data
    logic load_out;  // move the result into the output register
  } crrb_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_hdr;  // read or done-read found a readable record
    logic view_hit;  // there is an oldest readable record
  } crrb_sts_t;

endpackage

// ===== design/crrb_ctrl.sv =====
// Sequencing state machine of the record ring buffer.
`timescale 1ns / 1ps

module crrb_ctrl
  import crrb_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  input  logic      cfg_valid,
  input  logic      rsp_ready,
  input  crrb_sts_t sts,
  output crrb_cmd_t cmd,
  output logic      req_ready,
  output logic      cfg_ready,
  output logic      rsp_valid
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_HDR,
    S_VIEW,
    S_VIEW_RD,
    S_FINISH
  } state_t;

  state_t state;
  logic   out_free;

  assign cfg_ready = (state == S_IDLE);
  assign req_ready = (state == S_IDLE) && !cfg_valid;
  assign out_free  = !rsp_valid || rsp_ready;

  always_comb begin
    cmd          = '0;
    cmd.cfg_wr   = cfg_valid && cfg_ready;
    cmd.accept   = req_valid && req_ready;
    cmd.exec     = (state == S_EXEC);
    cmd.hdr      = (state == S_HDR);
    cmd.view     = (state == S_VIEW);
    cmd.view_cap = (state == S_VIEW_RD);
    cmd.load_out = (state == S_FINISH) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd.accept) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          state <= sts.need_hdr ? S_HDR : S_VIEW;
        end
        S_HDR: begin
          state <= S_VIEW;
        end
        S_VIEW: begin
          state <= sts.view_hit ? S_VIEW_RD : S_FINISH;
        end
        S_VIEW_RD: begin
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (out_free) begin
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== design/crrb_dp.sv =====
// Datapath of the record ring buffer: ring memory, pointers, result register.
`timescale 1ns / 1ps

module crrb_dp
  import crrb_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  crrb_cmd_t        cmd,
  input  crrb_req_t        req,
  input  logic [PTR_W-1:0] cfg_data,
  output crrb_sts_t        sts,
  output crrb_rsp_t        rsp
);

  function automatic logic [PTR_W-1:0] clamp_size(input logic [PTR_W-1:0] v);
    logic [PTR_W-1:0] r;
    r = v;
    if (v < RING_SIZE_MIN) r = RING_SIZE_MIN;
    else if (v > RING_SIZE_RESET) r = RING_SIZE_RESET;
    return r;
  endfunction

  logic [WORD_BITS-1:0] mem [DEPTH];

  // Control state
  logic [PTR_W-1:0] ring_size, ring_size_next;
  logic [PTR_W-1:0] read_start, read_start_next;
  logic [PTR_W-1:0] valid_end, valid_end_next;
  logic [PTR_W-1:0] write_base, write_base_next;
  logic [LEN_W-1:0] pending_len, pending_len_next;
  logic [LEN_W-1:0] words_written, words_written_next;
  logic             record_open, record_open_next;

  // Item and result payload
  crrb_req_t            item;
  logic [STS_W-1:0]     status, status_next;
  logic                 done, done_next;
  logic                 dout_pend, dout_pend_next;
  logic [WORD_BITS-1:0] dout;
  logic [LEN_W-1:0]     oldest;
  logic [WORD_BITS-1:0] rd_data;

  // Memory port
  logic                 mem_we;
  logic [ADDR_W-1:0]    mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic [ADDR_W-1:0]    rd_addr;

  // Pointer arithmetic
  logic             rd_wrap;
  logic [PTR_W-1:0] rs_w, ve_w;
  logic [PTR_W-1:0] need, wb_eff, commit_need, data_addr, hdr_step, off_addr;
  logic [SUM_W-1:0] wb_need, eff_need;
  logic             wb_wrap, no_room;
  logic [LEN_W-1:0] ww_inc, hdr_len;

  // Reader wraps once drained to the valid end behind a wrapped writer
  assign rd_wrap = (read_start == valid_end) && (write_base < valid_end);
  assign rs_w    = rd_wrap ? '0 : read_start;
  assign ve_w    = rd_wrap ? write_base : valid_end;

  assign need     = {1'b0, item.record_len} + HDR_WORDS;
  assign wb_need  = {1'b0, write_base} + {1'b0, need};
  assign wb_wrap  = (write_base == valid_end) && (wb_need > {1'b0, ring_size});
  assign wb_eff   = wb_wrap ? '0 : write_base;
  assign eff_need = {1'b0, wb_eff} + {1'b0, need};
  assign no_room  = (wb_eff < valid_end) && (eff_need >= {1'b0, read_start});

  assign ww_inc      = words_written + LEN_W'(1);
  assign commit_need = {1'b0, pending_len} + HDR_WORDS;
  assign data_addr   = write_base + HDR_WORDS + {1'b0, words_written};

  assign hdr_len  = rd_data[LEN_W-1:0];
  assign hdr_step = HDR_WORDS + {1'b0, hdr_len};
  assign off_addr = read_start + HDR_WORDS + {1'b0, item.read_offset};

  always_comb begin
    ring_size_next     = ring_size;
    read_start_next    = read_start;
    valid_end_next     = valid_end;
    write_base_next    = write_base;
    pending_len_next   = pending_len;
    words_written_next = words_written;
    record_open_next   = record_open;
    status_next        = status;
    done_next          = done;
    dout_pend_next     = dout_pend;
    mem_we             = 1'b0;
    mem_waddr          = write_base[ADDR_W-1:0];
    mem_wdata          = '0;
    rd_addr            = read_start[ADDR_W-1:0];
    sts                = '0;

    if (cmd.cfg_wr) begin
      ring_size_next     = clamp_size(cfg_data);
      read_start_next    = '0;
      valid_end_next     = '0;
      write_base_next    = '0;
      pending_len_next   = '0;
      words_written_next = '0;
      record_open_next   = 1'b0;
    end else if (cmd.accept) begin
      status_next    = STS_OK;
      done_next      = 1'b0;
      dout_pend_next = 1'b0;
    end else if (cmd.exec) begin
      case (item.op) inside
        OP_BEGIN: begin
          if (record_open) begin
            status_next = STS_SEQ_ERR;
          end else if (item.record_len == '0) begin
            status_next = STS_ZERO_LEN;
          end else if (need > ring_size) begin
            status_next = STS_TOO_LARGE;
          end else begin
            // a wrap decided here stands even on a retry
            write_base_next = wb_eff;
            if (no_room) begin
              status_next = STS_NO_SPACE;
            end else begin
              mem_we             = 1'b1;
              mem_waddr          = wb_eff[ADDR_W-1:0];
              mem_wdata          = {{(WORD_BITS-LEN_W){1'b0}}, item.record_len};
              pending_len_next   = item.record_len;
              words_written_next = '0;
              record_open_next   = 1'b1;
            end
          end
        end
        OP_DATA: begin
          if (!record_open) begin
            status_next = STS_SEQ_ERR;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = data_addr[ADDR_W-1:0];
            mem_wdata = item.data_in;
            if (ww_inc == pending_len) begin
              if (write_base == valid_end) begin
                valid_end_next = valid_end + commit_need;
              end
              write_base_next    = write_base + commit_need;
              record_open_next   = 1'b0;
              words_written_next = '0;
              done_next          = 1'b1;
            end else begin
              words_written_next = ww_inc;
            end
          end
        end
        OP_READ, OP_DONE: begin
          read_start_next = rs_w;
          valid_end_next  = ve_w;
          if (rs_w < ve_w) begin
            sts.need_hdr = 1'b1;
            rd_addr      = rs_w[ADDR_W-1:0];
          end else begin
            status_next = STS_EMPTY;
          end
        end
      endcase
    end else if (cmd.hdr) begin
      if (item.op == OP_READ) begin
        if (item.read_offset >= hdr_len) begin
          status_next = STS_OFFSET;
        end else begin
          dout_pend_next = 1'b1;
          rd_addr        = off_addr[ADDR_W-1:0];
        end
      end else begin
        read_start_next = read_start + hdr_step;
      end
    end else if (cmd.view) begin
      sts.view_hit = (rs_w < ve_w);
      rd_addr      = rs_w[ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_size     <= RING_SIZE_RESET;
      read_start    <= '0;
      valid_end     <= '0;
      write_base    <= '0;
      pending_len   <= '0;
      words_written <= '0;
      record_open   <= 1'b0;
    end else begin
      ring_size     <= ring_size_next;
      read_start    <= read_start_next;
      valid_end     <= valid_end_next;
      write_base    <= write_base_next;
      pending_len   <= pending_len_next;
      words_written <= words_written_next;
      record_open   <= record_open_next;
    end
  end

  always_ff @(posedge clk) begin
    status    <= status_next;
    done      <= done_next;
    dout_pend <= dout_pend_next;
    if (cmd.accept) begin
      item <= req;
      dout <= '0;
    end
    if (cmd.view && dout_pend) begin
      dout <= rd_data;
    end
    if (cmd.view && !sts.view_hit) begin
      oldest <= '0;
    end
    if (cmd.view_cap) begin
      oldest <= rd_data[LEN_W-1:0];
    end
    if (cmd.load_out) begin
      rsp.status     <= status;
      rsp.data_out   <= dout;
      rsp.oldest_len <= oldest;
      rsp.committed  <= done;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== design/contiguous_record_ring_buffer_unit.sv =====
// Top level of the contiguous record ring buffer.
`timescale 1ns / 1ps

// Ring of 1024 32-bit words holding variable-length records, each a length
// header followed by its data words, never split across the end of the ring.
// op 0 opens a record (status 1 means no room yet: retry later), op 1 writes
// the next data word and the last one commits the record, op 2 reads a word
// of the oldest committed record by offset, op 3 frees that record. Every
// item gives exactly one result item carrying status, read data, the length
// of the oldest readable record afterwards and a commit flag. Items are
// handled one at a time. After acceptance an item passes through execute,
// a header step for a read or done-read that finds a record, the lookup of
// the oldest readable record, a step capturing its length when there is
// one, and the output step, which waits while the output register still
// holds an untaken result. The single read port of the ring memory sets
// these steps: its registered data is needed once for the record header,
// once for the read word and once to look up the new oldest record. The
// next item is taken while the result still waits in the output register.
// Writing the ring size (clamped to 2..1024, headers included) empties the
// ring and drops any open record; it is taken only between items and wins
// over a waiting item. No clearing pass runs after reset.
module contiguous_record_ring_buffer_unit
  import crrb_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  // item channel
  input  logic             req_valid,
  output logic             req_ready,
  input  crrb_req_t        req,
  // result channel
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output crrb_rsp_t        rsp,
  // ring size register
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [PTR_W-1:0] cfg_data
);

  crrb_cmd_t cmd;   // sequencing commands
  crrb_sts_t sts;   // pointer compare outcomes

  // Controller: walks each item through execute, header, lookup, capture, output
  crrb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .cfg_valid (cfg_valid),
    .rsp_ready (rsp_ready),
    .sts       (sts),
    .cmd       (cmd),
    .req_ready (req_ready),
    .cfg_ready (cfg_ready),
    .rsp_valid (rsp_valid)
  );

  // Datapath: ring memory, start/end/write pointers, result register
  crrb_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .req      (req),
    .cfg_data (cfg_data),
    .sts      (sts),
    .rsp      (rsp)
  );

endmodule

// ===== verif/contiguous_record_ring_buffer_unit_tb.sv =====
// Self-checking testbench of the contiguous record ring buffer unit.
`timescale 1ns / 1ps

module contiguous_record_ring_buffer_unit_tb;
  import crrb_pkg::*;

  // Cycles with no handshake on any channel before the run is called hung.
  // The longest correct quiet stretch is the long receiver hold-off below.
  localparam int STALL_LIMIT = 4000;
  localparam int LONG_HOLD   = 250;  // receiver hold-off that backs the block up
  localparam int HOLD_AFTER  = 300;  // results taken before that hold-off starts
  localparam int PHASE_ITEMS = 40;   // random items per ring size setting

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             req_valid = 1'b0;
  logic             req_ready;
  crrb_req_t        req = '0;
  logic             rsp_valid;
  logic             rsp_ready = 1'b0;
  crrb_rsp_t        rsp;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [PTR_W-1:0] cfg_data = '0;

  contiguous_record_ring_buffer_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Ring predictor: own copy of the ring image, pointers and ring size.
  // Pointers are kept as plain unsigned ints so that sums never wrap.
  // ---------------------------------------------------------------------
  logic [WORD_BITS-1:0] ring_img [DEPTH];
  int unsigned rd_ptr     = 0;      // start of the oldest record
  int unsigned vend       = 0;      // end of the readable region
  int unsigned wr_base    = 0;      // where the next record goes
  int unsigned open_len   = 0;      // data words of the record being written
  int unsigned fill_cnt   = 0;      // data words written so far
  bit          rec_open   = 1'b0;
  int unsigned ring_words = DEPTH;  // ring size in use, headers included

  crrb_req_t   pend_q [$];          // items waiting for the driver
  crrb_rsp_t   rsp_exp_q [$];       // results still owed by the block
  int          errors = 0;
  bit          calm = 1'b0;         // no idling on either side

  function automatic int unsigned hdr_at(int unsigned a);
    return int'(ring_img[a % DEPTH][LEN_W-1:0]);
  endfunction

  // Reader drained to the valid end while the writer has wrapped: follow it.
  function automatic void reader_align();
    if (rd_ptr == vend && wr_base < vend) begin
      rd_ptr = 0;
      vend   = wr_base;
    end
  endfunction

  // Same lookup, without moving the reader.
  function automatic logic [LEN_W-1:0] oldest_view();
    int unsigned s;
    int unsigned e;
    s = rd_ptr;
    e = vend;
    if (s == e && wr_base < e) begin
      s = 0;
      e = wr_base;
    end
    return (s < e) ? LEN_W'(hdr_at(s)) : '0;
  endfunction

  function automatic void set_ring_words(logic [PTR_W-1:0] v);
    if (v < RING_SIZE_MIN) ring_words = int'(RING_SIZE_MIN);
    else if (v > DEPTH) ring_words = DEPTH;
    else ring_words = int'(v);
    rd_ptr   = 0;
    vend     = 0;
    wr_base  = 0;
    open_len = 0;
    fill_cnt = 0;
    rec_open = 1'b0;
  endfunction

  function automatic logic [STS_W-1:0] open_record(logic [LEN_W-1:0] len);
    int unsigned need;
    if (rec_open) return STS_SEQ_ERR;
    if (len == '0) return STS_ZERO_LEN;
    need = int'(len) + int'(HDR_WORDS);
    if (need > ring_words) return STS_TOO_LARGE;
    if (wr_base < vend && wr_base + need >= rd_ptr) return STS_NO_SPACE;
    // Would cross the end: wrap, and keep the wrap even if refused next.
    if (wr_base == vend && wr_base + need > ring_words) begin
      wr_base = 0;
      if (wr_base < vend && wr_base + need >= rd_ptr) return STS_NO_SPACE;
    end
    ring_img[wr_base % DEPTH] = WORD_BITS'(len);
    open_len = int'(len);
    fill_cnt = 0;
    rec_open = 1'b1;
    return STS_OK;
  endfunction

  function automatic crrb_rsp_t ring_result(crrb_req_t it);
    crrb_rsp_t   r;
    int unsigned need;
    r = '0;
    r.status = STS_OK;
    case (it.op)
      OP_BEGIN: r.status = open_record(it.record_len);
      OP_DATA: begin
        if (!rec_open) begin
          r.status = STS_SEQ_ERR;
        end else begin
          ring_img[(wr_base + int'(HDR_WORDS) + fill_cnt) % DEPTH] = it.data_in;
          fill_cnt = (fill_cnt + 1) & 32'h3FF;
          if (fill_cnt == open_len) begin
            need = open_len + int'(HDR_WORDS);
            if (wr_base == vend) vend = vend + need;
            wr_base     = wr_base + need;
            rec_open    = 1'b0;
            fill_cnt    = 0;
            r.committed = 1'b1;
          end
        end
      end
      OP_READ, OP_DONE: begin
        reader_align();
        if (rd_ptr >= vend) begin
          r.status = STS_EMPTY;
        end else if (it.op == OP_DONE) begin
          rd_ptr = rd_ptr + int'(HDR_WORDS) + hdr_at(rd_ptr);
        end else if (int'(it.read_offset) >= hdr_at(rd_ptr)) begin
          r.status = STS_OFFSET;
        end else begin
          r.data_out = ring_img[(rd_ptr + int'(HDR_WORDS) + it.read_offset) % DEPTH];
        end
      end
    endcase
    r.oldest_len = oldest_view();
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Scoreboard: results are checked before new expectations are added, and
  // a single process owns the queue.
  // ---------------------------------------------------------------------
  task automatic check_field(string name, logic [WORD_BITS-1:0] exp_v,
                             logic [WORD_BITS-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    crrb_rsp_t want;
    if (!rst) begin
      if (rsp_valid && rsp_ready) begin
        if (rsp_exp_q.size() == 0) begin
          $display("%0t: result item with none expected, expected nothing, got %0h",
                   $time, rsp);
          errors++;
        end else begin
          want = rsp_exp_q.pop_front();
          check_field("status", want.status, rsp.status);
          check_field("data_out", want.data_out, rsp.data_out);
          check_field("oldest_len", want.oldest_len, rsp.oldest_len);
          check_field("committed", want.committed, rsp.committed);
        end
      end
      if (cfg_valid && cfg_ready) set_ring_words(cfg_data);
      if (req_valid && req_ready) rsp_exp_q.push_back(ring_result(req));
    end
  end

  // ---------------------------------------------------------------------
  // Driver: takes items from pend_q, holds each until accepted, and puts
  // random gaps after some of them.
  // ---------------------------------------------------------------------
  int gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_ready) begin
      if (req_valid && !calm && $urandom_range(0, 4) == 0)
        gap_left = $urandom_range(1, 12);
      if (gap_left > 0) begin
        gap_left--;
        req_valid <= 1'b0;
      end else if (pend_q.size() != 0) begin
        req       <= pend_q.pop_front();
        req_valid <= 1'b1;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result sink: random stall bursts, plus one long hold-off once enough
  // results have gone by and the sender is offering, so that the output
  // register and the item in flight back up into req_ready.
  // ---------------------------------------------------------------------
  int  stall_left = 0;
  int  hold_left  = 0;
  int  rsp_seen   = 0;
  bit  held       = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) rsp_seen++;
      if (hold_left > 0) begin
        hold_left--;
        rsp_ready <= 1'b0;
      end else if (!held && rsp_seen >= HOLD_AFTER && req_valid) begin
        held      = 1'b1;
        hold_left = LONG_HOLD;
        rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 11);
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles with no handshake at all.
  int quiet = 0;

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, quiet);
      $display("FAIL contiguous_record_ring_buffer_unit");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  task automatic push_item(logic [OP_W-1:0] op, logic [LEN_W-1:0] len,
                           logic [WORD_BITS-1:0] din, logic [LEN_W-1:0] off);
    crrb_req_t it;
    it.op          = op;
    it.record_len  = len;
    it.data_in     = din;
    it.read_offset = off;
    pend_q.push_back(it);
  endtask

  // Sender stops; wait until every result is back and the block has settled.
  task automatic wait_drained();
    do @(negedge clk);
    while (pend_q.size() != 0 || req_valid || rsp_exp_q.size() != 0);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_ring_size(int v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= PTR_W'(v);
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // A whole record: header then its data words, unused fields random.
  task automatic push_record(int len);
    push_item(OP_BEGIN, LEN_W'(len), $urandom, LEN_W'($urandom));
    for (int k = 0; k < len; k++)
      push_item(OP_DATA, LEN_W'($urandom), $urandom, LEN_W'($urandom));
  endtask

  // Mostly well-formed writer and reader traffic sized to the ring, with
  // retries, refused lengths, stray offsets and some pure noise.
  task automatic add_traffic(int n_items, int max_len);
    int added;
    int pick;
    int len;
    int nrd;
    int cap;
    added = 0;
    while (added < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        cap = (max_len < 6) ? max_len : 6;
        len = $urandom_range(1, cap);
        if ($urandom_range(0, 6) == 0) begin
          cap = (max_len < 40) ? max_len : 40;
          len = $urandom_range(1, cap);
        end
        // an oversize length now and then
        if (max_len < 1023 && $urandom_range(0, 19) == 0) begin
          push_item(OP_BEGIN, LEN_W'($urandom_range(max_len + 1, 1023)), $urandom,
                    LEN_W'($urandom));
          added++;
        end
        push_record(len);
        added += len + 1;
        // header again: sequence error, or a retry after a refusal
        if ($urandom_range(0, 9) == 0) begin
          push_record(len);
          added += len + 1;
        end
      end else if (pick < 75) begin
        nrd = $urandom_range(1, 3);
        for (int k = 0; k < nrd; k++) begin
          if ($urandom_range(0, 4) == 0)
            push_item(OP_READ, LEN_W'($urandom), $urandom, LEN_W'($urandom_range(0, 1023)));
          else
            push_item(OP_READ, LEN_W'($urandom), $urandom, LEN_W'($urandom_range(0, 7)));
        end
        added += nrd;
      end else if (pick < 93) begin
        push_item(OP_DONE, LEN_W'($urandom), $urandom, LEN_W'($urandom));
        added++;
      end else begin
        // noise; on big rings no random headers, which would open huge records
        push_item(OP_W'($urandom_range((max_len < 511) ? 0 : 1, 3)), LEN_W'($urandom),
                  $urandom, LEN_W'($urandom));
        added++;
      end
    end
  endtask

  initial begin
    int sizes [9];
    int eff;
    int big;

    sizes = '{0, 3, 16, 37, 2047, 1, 64, 1024, 9};
    foreach (ring_img[i]) ring_img[i] = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed, reset ring size: empty reads, stray data, zero length,
    // sequence error on a second header, offsets at and past the end.
    push_item(OP_READ, '0, '0, '0);
    push_item(OP_DONE, '0, '0, '0);
    push_item(OP_DATA, '0, 32'hDEAD_BEEF, '0);
    push_item(OP_BEGIN, '0, '0, '0);
    push_item(OP_BEGIN, LEN_W'(3), '0, '0);
    push_item(OP_BEGIN, LEN_W'(2), '0, '0);
    push_item(OP_DATA, '0, 32'h0000_0001, '0);
    push_item(OP_DATA, '0, 32'h8000_0000, '0);
    push_item(OP_DATA, '0, 32'h5A5A_A5A5, '0);
    push_item(OP_READ, '0, '0, '0);
    push_item(OP_READ, '0, '0, LEN_W'(2));
    push_item(OP_READ, '0, '0, LEN_W'(3));
    push_item(OP_READ, '1, '1, '1);
    push_item(OP_DONE, '0, '0, '0);
    push_item(OP_READ, '0, '0, '0);
    wait_drained();

    // Tiny ring: too large, exact fit, refused header after a wrap, retry.
    write_ring_size(4);
    push_item(OP_BEGIN, '1, '0, '0);
    push_item(OP_BEGIN, LEN_W'(4), '0, '0);
    push_item(OP_BEGIN, LEN_W'(3), '0, '0);
    push_item(OP_DATA, '0, '1, '0);
    push_item(OP_DATA, '0, '0, '0);
    push_item(OP_DATA, '0, 32'hA5A5_5A5A, '0);
    push_item(OP_BEGIN, LEN_W'(1), '0, '0);
    push_item(OP_READ, '0, '0, LEN_W'(2));
    push_item(OP_DONE, '0, '0, '0);
    push_item(OP_BEGIN, LEN_W'(1), '0, '0);
    push_item(OP_DATA, '0, 32'h1234_5678, '0);
    push_item(OP_READ, '0, '0, '0);
    push_item(OP_DONE, '0, '0, '0);
    push_item(OP_READ, '0, '0, '0);
    wait_drained();

    // Random phases over several ring sizes, the clamped extremes among
    // them; the sender drains before each size change.
    foreach (sizes[p]) begin
      if (p == $size(sizes) - 1) calm = 1'b1;
      write_ring_size(sizes[p]);
      eff = (sizes[p] < 2) ? 2 : ((sizes[p] > DEPTH) ? DEPTH : sizes[p]);
      if (eff >= 512) begin
        // one long record, read near its end and just past it
        big = $urandom_range(100, 250);
        push_record(big);
        push_item(OP_READ, '0, '0, LEN_W'(big - 1));
        push_item(OP_READ, '0, '0, LEN_W'(big));
        push_item(OP_READ, '0, '0, LEN_W'($urandom_range(0, big - 1)));
        push_item(OP_DONE, '0, '0, '0);
      end
      add_traffic(PHASE_ITEMS, eff - 1);
      wait_drained();
    end

    repeat (20) @(negedge clk);
    if (errors == 0) begin
      $display("PASS contiguous_record_ring_buffer_unit");
    end else begin
      $display("FAIL contiguous_record_ring_buffer_unit");
    end
    $finish;
  end

endmodule

// ===== contiguous_record_ring_buffer_unit.f =====
design/crrb_pkg.sv
design/crrb_ctrl.sv
design/crrb_dp.sv
design/contiguous_record_ring_buffer_unit.sv
verif/contiguous_record_ring_buffer_unit_tb.sv
